@@ hdl/gthm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gthm_pkg
// Shared constants and types of the ground-to-source homography map.
// ----------------------------------------------------------------------------
package gthm_pkg;

  localparam int COEFF_WIDTH_DEF = 21;
  localparam int PIXEL_WIDTH_DEF = 16;

  localparam int IN_W       = 24;
  localparam int PPM_W      = 24;
  localparam int PPM_FRAC_W = 16;
  localparam int ONE_SHIFT  = 8;
  localparam int ROW_W      = 63;
  localparam int SIZE_W     = 14;
  localparam int TEX_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PPM    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd6;

  localparam logic [PPM_W-1:0]  PPM_RST    = 24'd256000;
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1080;

  typedef struct packed {
    logic fault;
    logic neg_x;
    logic neg_y;
  } proj_flags_t;

  typedef struct packed {
    logic in_img;
    logic fault;
  } res_flags_t;

endpackage
`default_nettype wire

@@ hdl/gthm_div_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gthm_div_pipe
// Unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module gthm_div_pipe #(
  parameter int N     = 30,
  parameter int TAG_W = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             vld_i,
  input  wire logic [N-1:0]     dividend_i,
  input  wire logic [N-1:0]     divisor_i,
  input  wire logic [TAG_W-1:0] tag_i,
  output logic                  vld_o,
  output logic [N-1:0]          quo_o,
  output logic                  rem_nz_o,
  output logic [TAG_W-1:0]      tag_o
);

  logic [N-1:0]     rem_r [0:N-1];
  logic [N-1:0]     dnd_r [0:N-1];
  logic [N-1:0]     dvs_r [0:N-1];
  logic [N-1:0]     quo_r [0:N-1];
  logic [TAG_W-1:0] tag_r [0:N-1];
  logic [N-1:0]     vld_r;

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [N-1:0]     rem_in;
    logic [N-1:0]     dnd_in;
    logic [N-1:0]     dvs_in;
    logic [N-1:0]     quo_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in;
    logic [N:0]       trial;
    logic [N:0]       diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dnd_in = dividend_i;
      assign dvs_in = divisor_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign dnd_in = dnd_r[i-1];
      assign dvs_in = dvs_r[i-1];
      assign quo_in = quo_r[i-1];
      assign tag_in = tag_r[i-1];
      assign vld_in = vld_r[i-1];
    end

    assign trial = {rem_in, dnd_in[N-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign ge    = ~diff[N];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? diff[N-1:0] : trial[N-1:0];
      dnd_r[i] <= {dnd_in[N-2:0], 1'b0};
      dvs_r[i] <= dvs_in;
      quo_r[i] <= {quo_in[N-2:0], ge};
      tag_r[i] <= tag_in;
    end
  end

  assign vld_o    = vld_r[N-1];
  assign quo_o    = quo_r[N-1];
  assign rem_nz_o = |rem_r[N-1];
  assign tag_o    = tag_r[N-1];

endmodule
`default_nettype wire

@@ hdl/gthm_proj.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gthm_proj
// Scale the ground point to ground pixels, apply the 3x3 matrix and split
// the three row sums into sign and magnitude for the dividers.
// ----------------------------------------------------------------------------
module gthm_proj #(
  parameter int COEFF_WIDTH = 21,
  parameter int ACC_W       = 56
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  vld_i,
  input  wire logic signed [gthm_pkg::IN_W-1:0]      gx_i,
  input  wire logic signed [gthm_pkg::IN_W-1:0]      gz_i,
  input  wire logic [gthm_pkg::ROW_W-1:0]            row0_i,
  input  wire logic [gthm_pkg::ROW_W-1:0]            row1_i,
  input  wire logic [gthm_pkg::ROW_W-1:0]            row2_i,
  input  wire logic [gthm_pkg::PPM_W-1:0]            ppm_i,
  output logic                                       vld_o,
  output logic [ACC_W-1:0]                           mag_x_o,
  output logic [ACC_W-1:0]                           mag_y_o,
  output logic [ACC_W-1:0]                           mag_w_o,
  output gthm_pkg::proj_flags_t                      flags_o
);

  import gthm_pkg::*;

  localparam int MUL_W  = IN_W + PPM_W + 1;
  localparam int PX_W   = MUL_W - PPM_FRAC_W;
  localparam int PROD_W = COEFF_WIDTH + PX_W;

  logic signed [COEFF_WIDTH-1:0] cf [0:2][0:2];
  logic [ROW_W-1:0]              rows [0:2];

  logic [4:0]                    vld_r;
  logic signed [IN_W-1:0]        gx_r, gz_r;
  logic signed [MUL_W-1:0]       mx, mz;
  logic signed [PX_W-1:0]        px_r, py_r;
  logic signed [PROD_W-1:0]      pr_r [0:2][0:1];
  logic signed [ACC_W-1:0]       acc_r [0:2];
  logic [ACC_W-1:0]              mag_r [0:2];
  proj_flags_t                   flags_r;

  assign rows[0] = row0_i;
  assign rows[1] = row1_i;
  assign rows[2] = row2_i;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign cf[r][c] = rows[r][c*COEFF_WIDTH +: COEFF_WIDTH];
    end
  end

  assign mx = gx_r * $signed({1'b0, ppm_i});
  assign mz = gz_r * $signed({1'b0, ppm_i});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    gx_r <= gx_i;
    gz_r <= gz_i;
    px_r <= mx[MUL_W-1:PPM_FRAC_W];
    py_r <= mz[MUL_W-1:PPM_FRAC_W];
  end

  for (genvar r = 0; r < 3; r++) begin : g_mac
    always_ff @(posedge clk) begin
      pr_r[r][0] <= cf[r][0] * px_r;
      pr_r[r][1] <= cf[r][1] * py_r;
      acc_r[r]   <= {{(ACC_W-PROD_W){pr_r[r][0][PROD_W-1]}}, pr_r[r][0]}
                  + {{(ACC_W-PROD_W){pr_r[r][1][PROD_W-1]}}, pr_r[r][1]}
                  + {{(ACC_W-COEFF_WIDTH-ONE_SHIFT){cf[r][2][COEFF_WIDTH-1]}},
                     cf[r][2], {ONE_SHIFT{1'b0}}};
      mag_r[r]   <= acc_r[r][ACC_W-1] ? (~acc_r[r] + ACC_W'(1)) : acc_r[r];
    end
  end

  always_ff @(posedge clk) begin
    flags_r.fault <= ~|acc_r[2];
    flags_r.neg_x <= acc_r[0][ACC_W-1] ^ acc_r[2][ACC_W-1];
    flags_r.neg_y <= acc_r[1][ACC_W-1] ^ acc_r[2][ACC_W-1];
  end

  assign vld_o   = vld_r[4];
  assign mag_x_o = mag_r[0];
  assign mag_y_o = mag_r[1];
  assign mag_w_o = mag_r[2];
  assign flags_o = flags_r;

endmodule
`default_nettype wire

@@ hdl/gthm_ratio.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gthm_ratio
// Turn unsigned quotients into truncated pixel coordinates, test the image
// bounds, saturate and form the texture dividends.
// ----------------------------------------------------------------------------
module gthm_ratio #(
  parameter int MAG_W       = 56,
  parameter int PIXEL_WIDTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       vld_i,
  input  wire logic [MAG_W-1:0]                           quo_x_i,
  input  wire logic                                       rnz_x_i,
  input  wire logic                                       neg_x_i,
  input  wire logic [MAG_W-1:0]                           quo_y_i,
  input  wire logic                                       rnz_y_i,
  input  wire logic                                       neg_y_i,
  input  wire logic                                       fault_i,
  input  wire logic [gthm_pkg::SIZE_W-1:0]                width_i,
  input  wire logic [gthm_pkg::SIZE_W-1:0]                height_i,
  output logic                                            vld_o,
  output logic [PIXEL_WIDTH-1:0]                          sx_o,
  output logic [PIXEL_WIDTH-1:0]                          sy_o,
  output gthm_pkg::res_flags_t                            flags_o,
  output logic [gthm_pkg::SIZE_W+gthm_pkg::TEX_W-1:0]     dnd_u_o,
  output logic [gthm_pkg::SIZE_W+gthm_pkg::TEX_W-1:0]     dnd_v_o
);

  import gthm_pkg::*;

  localparam int S_W   = MAG_W + 2;
  localparam int TEX_N = SIZE_W + TEX_W;

  logic [3:0]             vld_r;
  logic [2:0]             fault_r;
  logic                   fault_d_r;
  logic [PIXEL_WIDTH-1:0] pix_r [0:1];
  logic                   inr_r [0:1];
  logic [TEX_N-1:0]       dnd_r [0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    fault_r   <= {fault_r[1:0], fault_i};
    fault_d_r <= fault_r[2];
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [MAG_W-1:0]  quo;
    logic              rnz;
    logic              neg;
    logic [SIZE_W-1:0] size;
    logic [S_W-1:0]    q_r, s_r, n_r;
    logic              rnz_a_r, rnz_b_r;
    logic [S_W-PIXEL_WIDTH:0] upper;
    logic              in_rng, pos_ovf, neg_ovf;

    if (l == 0) begin : g_x
      assign quo  = quo_x_i;
      assign rnz  = rnz_x_i;
      assign neg  = neg_x_i;
      assign size = width_i;
    end else begin : g_y
      assign quo  = quo_y_i;
      assign rnz  = rnz_y_i;
      assign neg  = neg_y_i;
      assign size = height_i;
    end

    assign upper   = n_r[S_W-1:PIXEL_WIDTH-1];
    assign in_rng  = ~n_r[S_W-1] && (n_r[S_W-2:0] < (S_W-1)'(size));
    assign pos_ovf = ~n_r[S_W-1] && (|upper);
    assign neg_ovf = n_r[S_W-1] && ~(&upper);

    always_ff @(posedge clk) begin
      q_r     <= neg ? (~{2'b00, quo} + {{(S_W-1){1'b0}}, ~rnz}) : {2'b00, quo};
      rnz_a_r <= rnz;
      s_r     <= q_r + S_W'(size >> 1);
      rnz_b_r <= rnz_a_r;
      n_r     <= s_r + S_W'(rnz_b_r & s_r[S_W-1]);
      dnd_r[l] <= {n_r[SIZE_W-1:0], {TEX_W{1'b0}}};
      inr_r[l] <= in_rng & ~fault_r[2];
      priority if (fault_r[2]) begin
        pix_r[l] <= '0;
      end else if (pos_ovf) begin
        pix_r[l] <= {1'b0, {(PIXEL_WIDTH-1){1'b1}}};
      end else if (neg_ovf) begin
        pix_r[l] <= {1'b1, {(PIXEL_WIDTH-1){1'b0}}};
      end else begin
        pix_r[l] <= n_r[PIXEL_WIDTH-1:0];
      end
    end
  end

  assign vld_o          = vld_r[3];
  assign sx_o           = pix_r[0];
  assign sy_o           = pix_r[1];
  assign flags_o.in_img = inr_r[0] & inr_r[1];
  assign flags_o.fault  = fault_d_r;
  assign dnd_u_o        = (inr_r[0] & inr_r[1]) ? dnd_r[0] : '0;
  assign dnd_v_o        = (inr_r[0] & inr_r[1]) ? dnd_r[1] : '0;

endmodule
`default_nettype wire

@@ hdl/ground_to_source_homography_map.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ground_to_source_homography_map
// Map a ground point to a source pixel and texture coordinate through a
// configured 3x3 homography.
//
//   channel  | ports                                   | handshake
//   request  | in_ground_x, in_ground_z                | start & !busy
//   result   | out_source_x/y, out_inside_res, out_tex_u/v,
//            | out_divide_fault                        | out_valid, 1 cycle
//   config   | cfg_we, cfg_idx, cfg_data               | write on cfg_we
//
// One request per cycle, busy stays low. A request passes in order through
// the projection, the x and y divider pipelines, the ratio stage and the
// u and v divider pipelines. Reset clears the valid bits and loads the
// register defaults. Nothing stalls: a result is shown for one cycle.
// ----------------------------------------------------------------------------
module ground_to_source_homography_map #(
  parameter int COEFF_WIDTH = gthm_pkg::COEFF_WIDTH_DEF,
  parameter int PIXEL_WIDTH = gthm_pkg::PIXEL_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [gthm_pkg::IN_W-1:0]     in_ground_x,
  input  wire logic signed [gthm_pkg::IN_W-1:0]     in_ground_z,
  output logic                                      out_valid,
  output logic signed [PIXEL_WIDTH-1:0]             out_source_x,
  output logic signed [PIXEL_WIDTH-1:0]             out_source_y,
  output logic                                      out_inside_res,
  output logic [gthm_pkg::TEX_W-1:0]                out_tex_u,
  output logic [gthm_pkg::TEX_W-1:0]                out_tex_v,
  output logic                                      out_divide_fault,
  input  wire logic                                 cfg_we,
  input  wire logic [gthm_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [gthm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import gthm_pkg::*;

  localparam int PX_W  = IN_W + PPM_W + 1 - PPM_FRAC_W;
  localparam int ACC_W = COEFF_WIDTH + PX_W + 2;
  localparam int TEX_N = SIZE_W + TEX_W;
  localparam int UTAG_W = 2 * PIXEL_WIDTH + 1;

  logic [ROW_W-1:0]  row0_r, row1_r, row2_r;
  logic [PPM_W-1:0]  ppm_r;
  logic [SIZE_W-1:0] width_r, height_r;

  logic              p_vld;
  logic [ACC_W-1:0]  mag_x, mag_y, mag_w;
  proj_flags_t       p_flags;

  logic              dx_vld;
  logic [ACC_W-1:0]  quo_x, quo_y;
  logic              rnz_x, rnz_y;
  logic [1:0]        dx_tag;
  logic              dy_tag;

  logic                   r_vld;
  logic [PIXEL_WIDTH-1:0] r_sx, r_sy;
  res_flags_t             r_flags;
  logic [TEX_N-1:0]       dnd_u, dnd_v;

  logic [TEX_N-1:0]  quo_u, quo_v;
  logic [UTAG_W-1:0] u_tag;
  logic              v_tag;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r   <= '0;
      row1_r   <= '0;
      row2_r   <= '0;
      ppm_r    <= PPM_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROW0:   row0_r   <= cfg_data[ROW_W-1:0];
        REG_ROW1:   row1_r   <= cfg_data[ROW_W-1:0];
        REG_ROW2:   row2_r   <= cfg_data[ROW_W-1:0];
        REG_PPM:    ppm_r    <= cfg_data[PPM_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  gthm_proj #(
    .COEFF_WIDTH (COEFF_WIDTH),
    .ACC_W       (ACC_W)
  ) u_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (start),
    .gx_i    (in_ground_x),
    .gz_i    (in_ground_z),
    .row0_i  (row0_r),
    .row1_i  (row1_r),
    .row2_i  (row2_r),
    .ppm_i   (ppm_r),
    .vld_o   (p_vld),
    .mag_x_o (mag_x),
    .mag_y_o (mag_y),
    .mag_w_o (mag_w),
    .flags_o (p_flags)
  );

  gthm_div_pipe #(.N(ACC_W), .TAG_W(2)) u_div_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (p_vld),
    .dividend_i (mag_x),
    .divisor_i  (mag_w),
    .tag_i      ({p_flags.fault, p_flags.neg_x}),
    .vld_o      (dx_vld),
    .quo_o      (quo_x),
    .rem_nz_o   (rnz_x),
    .tag_o      (dx_tag)
  );

  gthm_div_pipe #(.N(ACC_W), .TAG_W(1)) u_div_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (p_vld),
    .dividend_i (mag_y),
    .divisor_i  (mag_w),
    .tag_i      (p_flags.neg_y),
    .vld_o      (),
    .quo_o      (quo_y),
    .rem_nz_o   (rnz_y),
    .tag_o      (dy_tag)
  );

  gthm_ratio #(
    .MAG_W       (ACC_W),
    .PIXEL_WIDTH (PIXEL_WIDTH)
  ) u_ratio (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (dx_vld),
    .quo_x_i  (quo_x),
    .rnz_x_i  (rnz_x),
    .neg_x_i  (dx_tag[0]),
    .quo_y_i  (quo_y),
    .rnz_y_i  (rnz_y),
    .neg_y_i  (dy_tag),
    .fault_i  (dx_tag[1]),
    .width_i  (width_r),
    .height_i (height_r),
    .vld_o    (r_vld),
    .sx_o     (r_sx),
    .sy_o     (r_sy),
    .flags_o  (r_flags),
    .dnd_u_o  (dnd_u),
    .dnd_v_o  (dnd_v)
  );

  gthm_div_pipe #(.N(TEX_N), .TAG_W(UTAG_W)) u_div_u (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (r_vld),
    .dividend_i (dnd_u),
    .divisor_i  (TEX_N'(width_r)),
    .tag_i      ({r_sx, r_sy, r_flags.fault}),
    .vld_o      (out_valid),
    .quo_o      (quo_u),
    .rem_nz_o   (),
    .tag_o      (u_tag)
  );

  gthm_div_pipe #(.N(TEX_N), .TAG_W(1)) u_div_v (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (r_vld),
    .dividend_i (dnd_v),
    .divisor_i  (TEX_N'(height_r)),
    .tag_i      (r_flags.in_img),
    .vld_o      (),
    .quo_o      (quo_v),
    .rem_nz_o   (),
    .tag_o      (v_tag)
  );

  assign out_source_x     = u_tag[UTAG_W-1 -: PIXEL_WIDTH];
  assign out_source_y     = u_tag[PIXEL_WIDTH:1];
  assign out_divide_fault = u_tag[0];
  assign out_inside_res   = v_tag;
  assign out_tex_u        = v_tag ? quo_u[TEX_W-1:0] : '0;
  assign out_tex_v        = v_tag ? quo_v[TEX_W-1:0] : '0;

endmodule
`default_nettype wire

@@ tb/ground_to_source_homography_map_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ground_to_source_homography_map_test
// Sends ground points through the homography map under several register
// settings and checks every mapped pixel, texture coordinate and flag
// against a behavioral projection computed in the bench.
// ----------------------------------------------------------------------------
module ground_to_source_homography_map_test;
  import gthm_pkg::*;

  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               in_img;
    logic [15:0]        u;
    logic [15:0]        v;
    logic               fault;
  } pixel_map_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [IN_W-1:0] in_ground_x;
  logic signed [IN_W-1:0] in_ground_z;
  logic out_valid;
  logic signed [15:0] out_source_x;
  logic signed [15:0] out_source_y;
  logic out_inside_res;
  logic [TEX_W-1:0] out_tex_u;
  logic [TEX_W-1:0] out_tex_v;
  logic out_divide_fault;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [ROW_W-1:0]  row_reg [3];
  logic [5:0]        frac_reg;
  logic [PPM_W-1:0]  ppm_reg;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;

  pixel_map_t pending_maps[$];
  int mismatches;
  bit steady_stream;

  ground_to_source_homography_map uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_ground_x(in_ground_x), .in_ground_z(in_ground_z),
    .out_valid(out_valid), .out_source_x(out_source_x),
    .out_source_y(out_source_y), .out_inside_res(out_inside_res),
    .out_tex_u(out_tex_u), .out_tex_v(out_tex_v),
    .out_divide_fault(out_divide_fault),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("ground_to_source_homography_map test failed");
    $finish;
  end

  function automatic longint coeff_of(input logic [ROW_W-1:0] row, input int col);
    logic signed [20:0] c;
    c = row[col*21 +: 21];
    return longint'(c);
  endfunction

  function automatic longint trunc_plus(input longint num, input longint den,
                                        input longint half);
    longint q;
    longint r;
    longint n;
    q = num / den;
    r = num % den;
    if (r != 0 && ((r < 0) != (den < 0))) q = q - 1;
    n = q + half;
    if (r != 0 && n < 0) n = n + 1;
    return n;
  endfunction

  function automatic logic signed [15:0] clamp_pixel(input longint val);
    if (val > 32767) return 16'sd32767;
    if (val < -32768) return -16'sd32768;
    return val[15:0];
  endfunction

  function automatic pixel_map_t map_point(input logic signed [IN_W-1:0] gx,
                                           input logic signed [IN_W-1:0] gz);
    pixel_map_t m;
    longint px;
    longint py;
    longint acc [3];
    longint wd;
    longint ht;
    longint tx;
    longint ty;
    px = (longint'(gx) * longint'({40'b0, ppm_reg})) >>> 16;
    py = (longint'(gz) * longint'({40'b0, ppm_reg})) >>> 16;
    for (int r = 0; r < 3; r++)
      acc[r] = coeff_of(row_reg[r], 0) * px + coeff_of(row_reg[r], 1) * py
               + coeff_of(row_reg[r], 2) * 256;
    m = '{sx: '0, sy: '0, in_img: 1'b0, u: '0, v: '0, fault: 1'b0};
    if (acc[2] == 0) begin
      m.fault = 1'b1;
    end else begin
      wd = longint'({50'b0, width_reg});
      ht = longint'({50'b0, height_reg});
      tx = trunc_plus(acc[0], acc[2], wd / 2);
      ty = trunc_plus(acc[1], acc[2], ht / 2);
      if (tx >= 0 && tx < wd && ty >= 0 && ty < ht) begin
        m.in_img = 1'b1;
        m.u = 16'((tx << 16) / wd);
        m.v = 16'((ty << 16) / ht);
      end
      m.sx = clamp_pixel(tx);
      m.sy = clamp_pixel(ty);
    end
    return m;
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(input longint c0, input longint c1,
                                                input longint c2);
    logic [20:0] a;
    logic [20:0] b;
    logic [20:0] c;
    a = c0[20:0];
    b = c1[20:0];
    c = c2[20:0];
    return {c, b, a};
  endfunction

  function automatic longint spread(input longint mag);
    return longint'($urandom_range(32'(2 * mag))) - mag;
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pixel_map_t e;
    if (rst_n && out_valid) begin
      if (pending_maps.size() == 0) begin
        report_mismatch("unrequested result", 1, 0);
      end else begin
        e = pending_maps.pop_front();
        if (out_source_x !== e.sx) report_mismatch("source_x", out_source_x, e.sx);
        if (out_source_y !== e.sy) report_mismatch("source_y", out_source_y, e.sy);
        if (out_inside_res !== e.in_img)
          report_mismatch("inside_res", out_inside_res, e.in_img);
        if (out_tex_u !== e.u) report_mismatch("tex_u", out_tex_u, e.u);
        if (out_tex_v !== e.v) report_mismatch("tex_v", out_tex_v, e.v);
        if (out_divide_fault !== e.fault)
          report_mismatch("divide_fault", out_divide_fault, e.fault);
      end
    end
  end

  task automatic send_request(input logic signed [IN_W-1:0] gx,
                              input logic signed [IN_W-1:0] gz);
    int gap;
    int pick;
    start <= 1'b1;
    in_ground_x <= gx;
    in_ground_z <= gz;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_maps.insert(pending_maps.size(), map_point(gx, gz));
    pick = $urandom_range(99);
    gap = steady_stream ? 0 : (pick < 60 ? 0 : (pick < 92 ? $urandom_range(1, 3)
                                                           : $urandom_range(20, 200)));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROW0:   row_reg[0] = data;
      REG_ROW1:   row_reg[1] = data;
      REG_ROW2:   row_reg[2] = data;
      REG_FRAC:   frac_reg = data[5:0];
      REG_PPM:    ppm_reg = data[PPM_W-1:0];
      REG_WIDTH:  width_reg = data[SIZE_W-1:0];
      REG_HEIGHT: height_reg = data[SIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_plain_matrix(input longint s, input longint off_x,
                                   input longint off_y);
    write_reg(REG_ROW0, pack_row(s, 0, off_x));
    write_reg(REG_ROW1, pack_row(0, s, off_y));
    write_reg(REG_ROW2, pack_row(0, 0, s));
  endtask

  task automatic test_reset_defaults;
    send_request(24'sd0, 24'sd0);
    send_request(24'sh7FFFFF, -24'sh800000);
    send_request(-24'sh800000, 24'sh7FFFFF);
    drain();
  endtask

  task automatic test_directed_extremes;
    load_plain_matrix(256, 0, 0);
    send_request(24'sd0, 24'sd0);
    send_request(24'sd65536, 24'sd32768);
    send_request(-24'sd65536, -24'sd32768);
    send_request(24'sh7FFFFF, 24'sh7FFFFF);
    send_request(-24'sh800000, -24'sh800000);
    send_request(24'sd62914, 24'sd35389);
    send_request(24'sd62915, 24'sd35390);
    drain();
    write_reg(REG_PPM, CFG_DATA_W'(1));
    write_reg(REG_FRAC, CFG_DATA_W'(0));
    send_request(24'sh7FFFFF, -24'sh800000);
    send_request(24'sd1, -24'sd1);
    drain();
    write_reg(REG_PPM, CFG_DATA_W'(24'hFFFFFF));
    write_reg(REG_FRAC, CFG_DATA_W'(40));
    write_reg(3'd7, '1);
    write_reg(REG_ROW0, pack_row(-1048576, 1048575, -1048576));
    write_reg(REG_ROW1, pack_row(1048575, -1048576, 1048575));
    write_reg(REG_ROW2, pack_row(1, -1, 1048575));
    send_request(24'sh7FFFFF, 24'sh7FFFFF);
    send_request(-24'sh800000, 24'sh7FFFFF);
    send_request(24'sd5, -24'sd3);
    drain();
  endtask

  task automatic test_divide_fault;
    write_reg(REG_PPM, CFG_DATA_W'(PPM_RST));
    write_reg(REG_ROW2, pack_row(1, -1, 0));
    send_request(24'sd0, 24'sd0);
    send_request(24'sd100, 24'sd100);
    send_request(24'sd100, 24'sd101);
    drain();
  endtask

  task automatic test_zero_size;
    load_plain_matrix(256, 0, 0);
    write_reg(REG_WIDTH, CFG_DATA_W'(0));
    write_reg(REG_HEIGHT, CFG_DATA_W'(0));
    send_request(24'sd0, 24'sd0);
    send_request(24'sd70, -24'sd70);
    drain();
    write_reg(REG_WIDTH, CFG_DATA_W'(1));
    write_reg(REG_HEIGHT, CFG_DATA_W'(1));
    send_request(24'sd0, 24'sd0);
    send_request(24'sd65, 24'sd65);
    drain();
    write_reg(REG_WIDTH, CFG_DATA_W'(16383));
    write_reg(REG_HEIGHT, CFG_DATA_W'(8192));
    send_request(24'sd0, 24'sd0);
    send_request(24'sd524287, -24'sd279000);
    drain();
  endtask

  task automatic test_random_mapping(input int count);
    longint s;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        drain();
        s = $urandom_range(64, 1024);
        write_reg(REG_ROW0, pack_row(s + spread(s / 8), spread(s / 8), spread(s * 200)));
        write_reg(REG_ROW1, pack_row(spread(s / 8), s + spread(s / 8), spread(s * 200)));
        write_reg(REG_ROW2, pack_row(spread(2), spread(2), s + spread(s / 8)));
        write_reg(REG_PPM, CFG_DATA_W'($urandom_range(1000, 512000)));
        write_reg(REG_FRAC, CFG_DATA_W'($urandom_range(63)));
        write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(1, 8192)));
        write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(1, 8192)));
        steady_stream = ($urandom_range(3) == 0);
      end
      send_request(24'(spread(65536)), 24'(spread(65536)));
    end
    drain();
    steady_stream = 1'b0;
  endtask

  task automatic test_random_raw(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        drain();
        write_reg(REG_ROW0, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_ROW1, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_ROW2, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_PPM, CFG_DATA_W'(24'($urandom)));
        write_reg(REG_WIDTH, CFG_DATA_W'(14'($urandom)));
        write_reg(REG_HEIGHT, CFG_DATA_W'(14'($urandom)));
      end
      send_request(24'($urandom), 24'($urandom));
    end
    drain();
  endtask

  initial begin
    mismatches = 0;
    steady_stream = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_ground_x = '0;
    in_ground_z = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    row_reg[0] = '0;
    row_reg[1] = '0;
    row_reg[2] = '0;
    frac_reg = 6'd15;
    ppm_reg = PPM_RST;
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_divide_fault();
    test_zero_size();
    test_random_mapping(520);
    test_random_raw(200);
    if (mismatches == 0) begin
      $display("ground_to_source_homography_map test passed");
    end else begin
      $display("ground_to_source_homography_map test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/gthm_pkg.sv
hdl/gthm_div_pipe.sv
hdl/gthm_proj.sv
hdl/gthm_ratio.sv
hdl/ground_to_source_homography_map.sv
tb/ground_to_source_homography_map_test.sv
